[rtl/core/assert_macros.svh]
// Assertion macros shared by the LCD nibble controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lcdn_pkg.sv]
// Types, constants and tables of the LCD nibble controller.
`default_nettype none
package lcdn_pkg;

    localparam int LCDN_BUF_DEPTH = 32;
    localparam int LCDN_ROWS      = 2;
    localparam int LCDN_COLS      = 16;

    // Reset values of the configuration registers
    localparam logic [7:0] LCDN_PWR_WAIT_RST   = 8'd20;
    localparam logic [7:0] LCDN_SECOND_WAIT_RST = 8'd5;
    localparam logic [7:0] LCDN_THIRD_WAIT_RST = 8'd1;

    // LCD command bytes and nibbles
    localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_LINE0      = 8'h80;
    localparam logic [7:0] CMD_LINE1      = 8'hC0;
    localparam logic [3:0] NIB_WAKE       = 4'h3;
    localparam logic [3:0] NIB_4BIT       = 4'h2;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PWR_WAIT    = 2'd0,
        CFG_SECOND_WAIT = 2'd1,
        CFG_THIRD_WAIT  = 2'd2
    } lcdn_cfg_idx_t;

    typedef enum logic [2:0] {
        KIND_TICK    = 3'd0,
        KIND_POLL    = 3'd1,
        KIND_STORE   = 3'd2,
        KIND_REFRESH = 3'd3,
        KIND_CLEAR   = 3'd4,
        KIND_CURSOR  = 3'd5,
        KIND_DIRECT  = 3'd6
    } lcdn_kind_t;

    typedef enum logic [1:0] {
        MODE_INIT     = 2'd0,
        MODE_IDLE     = 2'd1,
        MODE_UPDATING = 2'd2
    } lcdn_mode_t;

    typedef enum logic [1:0] {
        WAIT_PULSE = 2'd0,
        WAIT_BYTE  = 2'd1,
        WAIT_CLEAR = 2'd2
    } lcdn_wait_t;

    // What the current item puts on the bus
    typedef enum logic [1:0] {
        PLAN_NONE      = 2'd0,
        PLAN_WAKE      = 2'd1,
        PLAN_INIT_TAIL = 2'd2,
        PLAN_BYTES     = 2'd3
    } lcdn_plan_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EMIT = 1'b1
    } lcdn_state_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [3:0] step;
        logic       last;
    } lcdn_cmd_t;

    typedef struct packed {
        logic [3:0] item_len;
    } lcdn_status_t;

    typedef struct packed {
        logic [3:0] nibble;
        lcdn_wait_t wcode;
    } lcdn_nib_t;

    localparam logic [3:0] INIT_TAIL_LEN = 4'd10;

    // Final power-up burst: wake, 4-bit mode, then four command bytes
    function automatic lcdn_nib_t init_tail_nibble(input logic [3:0] step);
        lcdn_nib_t n;
        case (step)
            4'd0:    n = '{NIB_WAKE, WAIT_PULSE};
            4'd1:    n = '{NIB_4BIT, WAIT_PULSE};
            4'd2:    n = '{CMD_FUNC_SET[7:4], WAIT_PULSE};
            4'd3:    n = '{CMD_FUNC_SET[3:0], WAIT_BYTE};
            4'd4:    n = '{CMD_DISPLAY_ON[7:4], WAIT_PULSE};
            4'd5:    n = '{CMD_DISPLAY_ON[3:0], WAIT_BYTE};
            4'd6:    n = '{CMD_CLEAR[7:4], WAIT_PULSE};
            4'd7:    n = '{CMD_CLEAR[3:0], WAIT_CLEAR};
            4'd8:    n = '{CMD_ENTRY_MODE[7:4], WAIT_PULSE};
            4'd9:    n = '{CMD_ENTRY_MODE[3:0], WAIT_BYTE};
            default: n = '{4'h0, WAIT_PULSE};
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

[rtl/core/char_lcd_nibble_controller.sv]
// Top level of the 4-bit character LCD nibble controller.
`default_nettype none
// An item is taken when start is high and busy is low. Each item yields
// 0, 1, 2, 4 or 10 nibble transfers, one per clock, the first on the result
// ports once the sequencer has entered its emit state and the output
// register has taken that nibble; busy stays high while the sequencer
// steps one nibble per clock through a single output register. Each
// transfer is on the result ports for one cycle only, marked by strobe; the
// receiver cannot stall, so it must take every strobed nibble. last marks
// the final nibble of an item. Config writes are always ready and take
// effect at once.
module char_lcd_nibble_controller
    import lcdn_pkg::*;
#(
    parameter int COLS = LCDN_COLS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] kind,
    input  wire logic [4:0] index,
    input  wire logic [7:0] char_code,
    input  wire logic       row,
    input  wire logic [5:0] col,
    output logic            strobe,
    output logic            rs,
    output logic [3:0]      nibble,
    output logic [1:0]      wait_code,
    output logic            last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    lcdn_cmd_t    cmd;
    lcdn_status_t status;

    assign cfg_ready = 1'b1;

    lcdn_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    lcdn_datapath #(
        .COLS (COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .kind      (kind),
        .index     (index),
        .char_code (char_code),
        .row       (row),
        .col       (col),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .rs        (rs),
        .nibble    (nibble),
        .wait_code (wait_code),
        .last      (last)
    );

endmodule
`default_nettype wire

[rtl/core/lcdn_ctrl.sv]
// Sequencer FSM: accepts items and steps through their nibble strobes.
`default_nettype none
`include "assert_macros.svh"
module lcdn_ctrl
    import lcdn_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  lcdn_status_t      status,
    output lcdn_cmd_t         cmd
);

    lcdn_state_t state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic [3:0]  len_reg, len_next;
    logic        at_last;

    assign at_last = (step_reg == len_reg - 4'd1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        len_next   = len_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && (status.item_len != 4'd0))
                begin
                    state_next = S_EMIT;
                    step_next  = 4'd0;
                    len_next   = status.item_len;
                end
            end
            S_EMIT:
            begin
                if (at_last)
                    state_next = S_IDLE;
                else
                    step_next = step_reg + 4'd1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd.load  = 1'b0;
        cmd.emit  = 1'b0;
        cmd.step  = step_reg;
        cmd.last  = at_last;
        busy      = 1'b0;
        case (state_reg)
            S_IDLE: cmd.load = start;
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                busy     = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 4'd0;
            len_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            len_reg   <= len_next;
        end
    end

    `ASSERT_IMPLIES(a_step_in_range, clk, rst_n, state_reg == S_EMIT, step_reg < len_reg, "step past item length")
    `ASSERT_NEXT(a_last_ends_item, clk, rst_n, cmd.emit && cmd.last, state_reg == S_IDLE, "sequencer did not stop after last nibble")
    `ASSERT_IMPLIES(a_no_load_busy, clk, rst_n, cmd.load, !busy, "item taken while busy")

endmodule
`default_nettype wire

[rtl/core/lcdn_datapath.sv]
// Datapath: config registers, power-up/refresh state, screen buffer, nibble output.
`default_nettype none
`include "assert_macros.svh"
module lcdn_datapath
    import lcdn_pkg::*;
#(
    parameter int COLS = LCDN_COLS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  lcdn_cmd_t        cmd,
    output lcdn_status_t     status,
    input  wire logic [2:0]  kind,
    input  wire logic [4:0]  index,
    input  wire logic [7:0]  char_code,
    input  wire logic        row,
    input  wire logic [5:0]  col,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output logic             strobe,
    output logic             rs,
    output logic [3:0]       nibble,
    output logic [1:0]       wait_code,
    output logic             last
);

    localparam int CELLS_RAW = LCDN_ROWS * COLS;
    localparam int CELLS = (CELLS_RAW < LCDN_BUF_DEPTH) ? CELLS_RAW : LCDN_BUF_DEPTH;
    localparam logic [5:0] CELLS_W = 6'(CELLS);
    localparam logic [5:0] COLS_W  = 6'(COLS);

    // Configuration
    logic [7:0] pwr_wait_reg, second_wait_reg, third_wait_reg;

    // Item-level state
    lcdn_mode_t mode_reg, mode_next;
    logic [1:0] pwr_phase_reg, pwr_phase_next;
    logic [7:0] wait_left_reg, wait_left_next;
    logic [5:0] ridx_reg, ridx_next;
    logic [7:0] buf_reg [LCDN_BUF_DEPTH];
    logic [7:0] buf_next [LCDN_BUF_DEPTH];

    // Latched plan for the current item
    lcdn_plan_t plan_reg, plan_next;
    logic       pre_en_reg, pre_en_next;
    logic [7:0] pre_byte_reg, pre_byte_next;
    logic [7:0] main_byte_reg, main_byte_next;
    logic       main_rs_reg, main_rs_next;

    // Output registers
    logic       strobe_reg;
    logic       rs_reg, rs_next;
    logic [3:0] nibble_reg, nibble_next;
    lcdn_wait_t wcode_reg, wcode_next;
    logic       last_reg;

    // Item decode and state update
    always_comb
    begin
        mode_next      = mode_reg;
        pwr_phase_next = pwr_phase_reg;
        wait_left_next = wait_left_reg;
        ridx_next      = ridx_reg;
        buf_next       = buf_reg;
        plan_next      = PLAN_NONE;
        pre_en_next    = 1'b0;
        pre_byte_next  = CMD_LINE0;
        main_byte_next = char_code;
        main_rs_next   = 1'b0;
        case (lcdn_kind_t'(kind))
            KIND_TICK:
            begin
                if (wait_left_reg != 8'd0)
                    wait_left_next = wait_left_reg - 8'd1;
            end
            KIND_POLL:
            begin
                if (mode_reg == MODE_INIT)
                begin
                    if (wait_left_reg == 8'd0)
                    begin
                        case (pwr_phase_reg)
                            2'd0:
                            begin
                                plan_next      = PLAN_WAKE;
                                wait_left_next = second_wait_reg;
                                pwr_phase_next = 2'd1;
                            end
                            2'd1:
                            begin
                                plan_next      = PLAN_WAKE;
                                wait_left_next = third_wait_reg;
                                pwr_phase_next = 2'd2;
                            end
                            default:
                            begin
                                plan_next = PLAN_INIT_TAIL;
                                mode_next = MODE_IDLE;
                            end
                        endcase
                    end
                end
                else if (mode_reg == MODE_UPDATING)
                begin
                    if (ridx_reg >= CELLS_W)
                        mode_next = MODE_IDLE;
                    else
                    begin
                        plan_next      = PLAN_BYTES;
                        pre_en_next    = (ridx_reg == 6'd0) || (ridx_reg == COLS_W);
                        pre_byte_next  = (ridx_reg == 6'd0) ? CMD_LINE0 : CMD_LINE1;
                        main_byte_next = buf_reg[ridx_reg[4:0]];
                        main_rs_next   = 1'b1;
                        ridx_next      = ridx_reg + 6'd1;
                    end
                end
            end
            KIND_STORE:
            begin
                if ({1'b0, index} < CELLS_W)
                    buf_next[index] = char_code;
            end
            KIND_REFRESH:
            begin
                ridx_next = 6'd0;
                mode_next = MODE_UPDATING;
            end
            KIND_CLEAR:
            begin
                for (int i = 0; i < LCDN_BUF_DEPTH; i++)
                    buf_next[i] = CHAR_SPACE;
                plan_next      = PLAN_BYTES;
                main_byte_next = CMD_CLEAR;
            end
            KIND_CURSOR:
            begin
                plan_next      = PLAN_BYTES;
                main_byte_next = (row ? CMD_LINE1 : CMD_LINE0) + {2'b00, col};
            end
            KIND_DIRECT:
            begin
                plan_next    = PLAN_BYTES;
                main_rs_next = 1'b1;
            end
            default: plan_next = PLAN_NONE;
        endcase
    end

    // Number of strobes the incoming item causes
    always_comb
    begin
        case (plan_next)
            PLAN_WAKE:      status.item_len = 4'd1;
            PLAN_INIT_TAIL: status.item_len = INIT_TAIL_LEN;
            PLAN_BYTES:     status.item_len = pre_en_next ? 4'd4 : 4'd2;
            default:        status.item_len = 4'd0;
        endcase
    end

    // Nibble for the current step
    always_comb
    begin
        logic [7:0] byte_sel;
        logic       rs_sel;
        lcdn_nib_t  tail;
        byte_sel    = main_byte_reg;
        rs_sel      = main_rs_reg;
        tail        = init_tail_nibble(cmd.step);
        rs_next     = 1'b0;
        nibble_next = NIB_WAKE;
        wcode_next  = WAIT_PULSE;
        if (pre_en_reg && !cmd.step[1])
        begin
            byte_sel = pre_byte_reg;
            rs_sel   = 1'b0;
        end
        case (plan_reg)
            PLAN_INIT_TAIL:
            begin
                nibble_next = tail.nibble;
                wcode_next  = tail.wcode;
            end
            PLAN_BYTES:
            begin
                rs_next = rs_sel;
                if (!cmd.step[0])
                    nibble_next = byte_sel[7:4];
                else
                begin
                    nibble_next = byte_sel[3:0];
                    wcode_next  = (!rs_sel && byte_sel == CMD_CLEAR) ? WAIT_CLEAR : WAIT_BYTE;
                end
            end
            default:
            begin
                nibble_next = NIB_WAKE;
                wcode_next  = WAIT_PULSE;
            end
        endcase
    end

    // Configuration and item state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwr_wait_reg    <= LCDN_PWR_WAIT_RST;
            second_wait_reg <= LCDN_SECOND_WAIT_RST;
            third_wait_reg  <= LCDN_THIRD_WAIT_RST;
            mode_reg        <= MODE_INIT;
            pwr_phase_reg   <= 2'd0;
            wait_left_reg   <= LCDN_PWR_WAIT_RST;
            ridx_reg        <= 6'd0;
            for (int i = 0; i < LCDN_BUF_DEPTH; i++)
                buf_reg[i] <= 8'h00;
            plan_reg        <= PLAN_NONE;
            strobe_reg      <= 1'b0;
            last_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                mode_reg      <= mode_next;
                pwr_phase_reg <= pwr_phase_next;
                wait_left_reg <= wait_left_next;
                ridx_reg      <= ridx_next;
                buf_reg       <= buf_next;
                plan_reg      <= plan_next;
            end
            if (cfg_write)
            begin
                case (lcdn_cfg_idx_t'(cfg_index))
                    CFG_PWR_WAIT:
                    begin
                        pwr_wait_reg <= cfg_data;
                        if (!cmd.load && mode_reg == MODE_INIT && pwr_phase_reg == 2'd0)
                            wait_left_reg <= cfg_data;
                    end
                    CFG_SECOND_WAIT: second_wait_reg <= cfg_data;
                    CFG_THIRD_WAIT:  third_wait_reg  <= cfg_data;
                    default:         third_wait_reg  <= third_wait_reg;
                endcase
            end
            strobe_reg <= cmd.emit;
            last_reg   <= cmd.emit && cmd.last;
        end
    end

    // Plan payload and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pre_en_reg    <= pre_en_next;
            pre_byte_reg  <= pre_byte_next;
            main_byte_reg <= main_byte_next;
            main_rs_reg   <= main_rs_next;
        end
        if (cmd.emit)
        begin
            rs_reg     <= rs_next;
            nibble_reg <= nibble_next;
            wcode_reg  <= wcode_next;
        end
    end

    assign strobe    = strobe_reg;
    assign rs        = rs_reg;
    assign nibble    = nibble_reg;
    assign wait_code = wcode_reg;
    assign last      = last_reg;

    `ASSERT_NEXT(a_strobe_follows_emit, clk, rst_n, cmd.emit, strobe_reg, "emit step without strobe")
    `ASSERT_IMPLIES(a_emit_has_plan, clk, rst_n, cmd.emit, plan_reg != PLAN_NONE, "emit with no plan")
    `ASSERT_IMPLIES(a_last_has_strobe, clk, rst_n, last_reg, strobe_reg, "last without strobe")

endmodule
`default_nettype wire
